>>> hdl/wnd_pkg.sv
// shared widths, types and constants of the weingarten normal derivatives unit
package wnd_pkg;

   localparam int COMP_BITS = 20;
   localparam int AXES = 3;
   localparam int FIELD_BITS = AXES * COMP_BITS;
   localparam int PROD_BITS = 2 * COMP_BITS;
   localparam int DOT_BITS = 2 * COMP_BITS + 2;
   localparam int HALF_BITS = DOT_BITS / 2;
   localparam int PART_BITS = 2 * (HALF_BITS + 1);
   localparam int FORM_BITS = 2 * DOT_BITS;
   localparam int DIFF_BITS = FORM_BITS + 1;
   localparam int CHUNK_BITS = (DIFF_BITS + 2) / 3;
   localparam int CPROD_BITS = CHUNK_BITS + 1 + COMP_BITS;
   localparam int NUM_BITS = DIFF_BITS + COMP_BITS + 1;
   localparam int QUO_BITS = COMP_BITS + 1;
   localparam int NUM_LANES = 2 * AXES;
   localparam int DIV_BASE = 9;
   localparam int STAGES = DIV_BASE + QUO_BITS + 2;

   typedef logic signed [COMP_BITS-1:0] comp_type;
   typedef logic signed [PROD_BITS-1:0] prod_type;
   typedef logic signed [DOT_BITS-1:0] dot_type;
   typedef logic signed [HALF_BITS:0] half_type;
   typedef logic signed [PART_BITS-1:0] part_type;
   typedef logic signed [FORM_BITS-1:0] form_type;
   typedef logic signed [DIFF_BITS-1:0] diff_type;
   typedef logic signed [CHUNK_BITS:0] chunk_type;
   typedef logic signed [CPROD_BITS-1:0] cprod_type;
   typedef logic signed [NUM_BITS-1:0] num_type;
   typedef logic [NUM_BITS-1:0] mag_type;
   typedef logic [DIFF_BITS-1:0] dmag_type;
   typedef logic [QUO_BITS-1:0] quo_type;

endpackage

>>> hdl/wnd_if.sv
// request and response channel interfaces
interface wnd_req_if;
   logic valid;
   logic ready;
   logic [wnd_pkg::FIELD_BITS-1:0] unit_normal;
   logic [wnd_pkg::FIELD_BITS-1:0] deriv_u;
   logic [wnd_pkg::FIELD_BITS-1:0] deriv_v;
   logic [wnd_pkg::FIELD_BITS-1:0] deriv_uu;
   logic [wnd_pkg::FIELD_BITS-1:0] deriv_uv;
   logic [wnd_pkg::FIELD_BITS-1:0] deriv_vv;

   modport source (output valid, unit_normal, deriv_u, deriv_v, deriv_uu, deriv_uv, deriv_vv,
                   input ready);
   modport sink (input valid, unit_normal, deriv_u, deriv_v, deriv_uu, deriv_uv, deriv_vv,
                 output ready);
endinterface

interface wnd_rsp_if;
   logic valid;
   logic ready;
   logic [wnd_pkg::FIELD_BITS-1:0] normal_du;
   logic [wnd_pkg::FIELD_BITS-1:0] normal_dv;
   logic degenerate;
   logic saturated;

   modport source (output valid, normal_du, normal_dv, degenerate, saturated, input ready);
   modport sink (input valid, normal_du, normal_dv, degenerate, saturated, output ready);
endinterface

>>> hdl/wnd_divider.sv
// pipelined restoring divider, six lanes sharing one divisor, one quotient bit per stage
module wnd_divider (
   input  logic                     clock,
   input  logic [wnd_pkg::QUO_BITS:0] load,
   input  wnd_pkg::mag_type         num_mag [wnd_pkg::NUM_LANES],
   input  wnd_pkg::dmag_type        den_mag,
   output wnd_pkg::quo_type         quotient [wnd_pkg::NUM_LANES],
   output logic [wnd_pkg::NUM_LANES-1:0] over
);
   import wnd_pkg::*;

   localparam int STEPS = QUO_BITS;
   localparam int TOP_BITS = NUM_BITS + 1 - QUO_BITS;

   dmag_type d_ff [0:STEPS-1];
   dmag_type r_ff [0:STEPS][NUM_LANES];
   dmag_type r_in [0:STEPS][NUM_LANES];
   quo_type x_ff [0:STEPS][NUM_LANES];
   quo_type x_in [0:STEPS][NUM_LANES];
   logic [NUM_LANES-1:0] over_ff [0:STEPS];
   logic [NUM_LANES-1:0] over_in;

   always_comb begin
      logic [TOP_BITS-1:0] top;
      logic [DIFF_BITS:0] t;
      logic ge;
      for (int l = 0; l < NUM_LANES; l++) begin
         top = num_mag[l][NUM_BITS-1:QUO_BITS-1];
         over_in[l] = top >= TOP_BITS'(den_mag);
         r_in[0][l] = top[DIFF_BITS-1:0];
         x_in[0][l] = {num_mag[l][QUO_BITS-2:0], 1'b0};
      end
      for (int s = 1; s <= STEPS; s++) begin
         for (int l = 0; l < NUM_LANES; l++) begin
            t = {r_ff[s-1][l], x_ff[s-1][l][QUO_BITS-1]};
            ge = t >= {1'b0, d_ff[s-1]};
            r_in[s][l] = ge ? DIFF_BITS'(t - {1'b0, d_ff[s-1]}) : t[DIFF_BITS-1:0];
            x_in[s][l] = {x_ff[s-1][l][QUO_BITS-2:0], ge};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         d_ff[0] <= den_mag;
         over_ff[0] <= over_in;
      end
      for (int s = 0; s <= STEPS; s++) begin
         if (load[s]) begin
            r_ff[s] <= r_in[s];
            x_ff[s] <= x_in[s];
         end
      end
      for (int s = 1; s <= STEPS; s++) begin
         if (load[s]) begin
            over_ff[s] <= over_ff[s-1];
         end
      end
      for (int s = 1; s < STEPS; s++) begin
         if (load[s]) begin
            d_ff[s] <= d_ff[s-1];
         end
      end
   end

   assign quotient = x_ff[STEPS];
   assign over = over_ff[STEPS];

endmodule

>>> hdl/weingarten_normal_derivatives_unit.sv
// top level of the weingarten normal derivatives unit
//
// req channel: one request carries the normal and the five position derivatives,
// each as three packed signed components. rsp channel: one response per request
// with dN/du and dN/dv, a degenerate flag and a saturation flag.
// an item is moved when valid and ready are both high.
// one request per cycle is taken while rsp.ready is high or a stage is empty. the depth
// is set by the 21 quotient stages of the shared-divisor divider plus 11 stages of
// products, form assembly and rounding.
// every stage carries its own valid bit; a stalled response holds the last stage
// and earlier stages keep advancing into empty slots, so requests are still taken
// until every stage is full.
// reset clears all valid bits; payload registers are not reset.
// a zero determinant gives zero outputs with degenerate set; components beyond
// range are clipped and flagged.
module weingarten_normal_derivatives_unit (
   input  logic     clock,
   input  logic     reset,
   wnd_req_if.sink  req,
   wnd_rsp_if.source rsp
);
   import wnd_pkg::*;

   localparam int NPROD = 9;
   localparam int PX [NPROD] = '{0, 1, 4, 3, 3, 4, 5, 4, 5};
   localparam int PY [NPROD] = '{2, 1, 1, 2, 1, 0, 1, 2, 0};
   localparam logic [QUO_BITS:0] LIM_POS = (QUO_BITS+1)'((1 << (COMP_BITS-1)) - 1);
   localparam logic [QUO_BITS:0] LIM_NEG = LIM_POS + (QUO_BITS+1)'(1);
   localparam logic [QUO_BITS:0] ONE_Q = (QUO_BITS+1)'(1);

   logic [STAGES-1:0] v_ff, v_in, load;

   comp_type n_c [AXES], pu_c [AXES], pv_c [AXES], puu_c [AXES], puv_c [AXES], pvv_c [AXES];
   comp_type pu_ff [0:4][AXES];
   comp_type pv_ff [0:4][AXES];
   prod_type prod_ff [6][AXES];
   prod_type prod_in [6][AXES];
   dot_type dot_ff [6];
   dot_type dot_in [6];
   part_type part_ff [NPROD][4];
   part_type part_in [NPROD][4];
   form_type form_ff [NPROD];
   form_type form_in [NPROD];
   diff_type diff_ff [5];
   diff_type diff_in [5];
   diff_type det_ff [5:7];
   cprod_type cp_ff [NUM_LANES][2][3];
   cprod_type cp_in [NUM_LANES][2][3];
   num_type term_ff [NUM_LANES][2];
   num_type term_in [NUM_LANES][2];
   num_type num_ff [NUM_LANES];
   mag_type mag_ff [NUM_LANES];
   mag_type mag_in [NUM_LANES];
   dmag_type dmag_ff;
   logic [NUM_LANES-1:0] neg_ff [8:STAGES-2];
   logic [NUM_LANES-1:0] neg_in;
   logic degen_ff [8:STAGES-2];
   quo_type quo [NUM_LANES];
   logic [NUM_LANES-1:0] over;
   logic [FIELD_BITS-1:0] du_ff, du_in, dv_ff, dv_in;
   logic degen_out_ff, sat_ff, sat_in;

   function automatic half_type hi_half(dot_type x);
      return half_type'(signed'(x[DOT_BITS-1:HALF_BITS]));
   endfunction

   function automatic half_type lo_half(dot_type x);
      return half_type'({1'b0, x[HALF_BITS-1:0]});
   endfunction

   function automatic chunk_type chunk(diff_type a, int c);
      if (c == 2) begin
         return chunk_type'(signed'(a[DIFF_BITS-1:2*CHUNK_BITS]));
      end
      return chunk_type'({1'b0, a[c*CHUNK_BITS +: CHUNK_BITS]});
   endfunction

   // stage handshake
   always_comb begin
      for (int i = 0; i < STAGES; i++) begin
         load[i] = rsp.ready || !(&(v_ff | ((STAGES'(1) << i) - STAGES'(1))));
         v_in[i] = (i == 0) ? req.valid : v_ff[(i == 0) ? 0 : i - 1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int i = 0; i < STAGES; i++) begin
            if (load[i]) begin
               v_ff[i] <= v_in[i];
            end
         end
      end
   end

   assign req.ready = load[0];
   assign rsp.valid = v_ff[STAGES-1];

   // unpack and component products
   always_comb begin
      for (int k = 0; k < AXES; k++) begin
         n_c[k] = comp_type'(req.unit_normal[k*COMP_BITS +: COMP_BITS]);
         pu_c[k] = comp_type'(req.deriv_u[k*COMP_BITS +: COMP_BITS]);
         pv_c[k] = comp_type'(req.deriv_v[k*COMP_BITS +: COMP_BITS]);
         puu_c[k] = comp_type'(req.deriv_uu[k*COMP_BITS +: COMP_BITS]);
         puv_c[k] = comp_type'(req.deriv_uv[k*COMP_BITS +: COMP_BITS]);
         pvv_c[k] = comp_type'(req.deriv_vv[k*COMP_BITS +: COMP_BITS]);
         prod_in[0][k] = pu_c[k] * pu_c[k];
         prod_in[1][k] = pu_c[k] * pv_c[k];
         prod_in[2][k] = pv_c[k] * pv_c[k];
         prod_in[3][k] = n_c[k] * puu_c[k];
         prod_in[4][k] = n_c[k] * puv_c[k];
         prod_in[5][k] = n_c[k] * pvv_c[k];
      end
   end

   // fundamental forms: E F G e f g
   always_comb begin
      for (int j = 0; j < 6; j++) begin
         dot_in[j] = dot_type'(prod_ff[j][0]) + dot_type'(prod_ff[j][1])
                   + dot_type'(prod_ff[j][2]);
      end
   end

   // split products of the forms
   always_comb begin
      for (int p = 0; p < NPROD; p++) begin
         part_in[p][0] = hi_half(dot_ff[PX[p]]) * hi_half(dot_ff[PY[p]]);
         part_in[p][1] = hi_half(dot_ff[PX[p]]) * lo_half(dot_ff[PY[p]]);
         part_in[p][2] = lo_half(dot_ff[PX[p]]) * hi_half(dot_ff[PY[p]]);
         part_in[p][3] = lo_half(dot_ff[PX[p]]) * lo_half(dot_ff[PY[p]]);
      end
   end

   always_comb begin
      for (int p = 0; p < NPROD; p++) begin
         form_in[p] = (form_type'(part_ff[p][0]) <<< (2 * HALF_BITS))
                    + ((form_type'(part_ff[p][1]) + form_type'(part_ff[p][2])) <<< HALF_BITS)
                    + form_type'(part_ff[p][3]);
      end
   end

   // det, a1, b1, a2, b2
   always_comb begin
      diff_in[0] = diff_type'(form_ff[0]) - diff_type'(form_ff[1]);
      diff_in[1] = diff_type'(form_ff[2]) - diff_type'(form_ff[3]);
      diff_in[2] = diff_type'(form_ff[4]) - diff_type'(form_ff[5]);
      diff_in[3] = diff_type'(form_ff[6]) - diff_type'(form_ff[7]);
      diff_in[4] = diff_type'(form_ff[2]) - diff_type'(form_ff[8]);
   end

   // numerator chunk products, du lanes then dv lanes
   always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
         for (int c = 0; c < 3; c++) begin
            cp_in[l][0][c] = chunk(diff_ff[(l < AXES) ? 1 : 3], c) * pu_ff[4][l % AXES];
            cp_in[l][1][c] = chunk(diff_ff[(l < AXES) ? 2 : 4], c) * pv_ff[4][l % AXES];
         end
      end
   end

   always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
         for (int t = 0; t < 2; t++) begin
            term_in[l][t] = (num_type'(cp_ff[l][t][2]) <<< (2 * CHUNK_BITS))
                          + (num_type'(cp_ff[l][t][1]) <<< CHUNK_BITS)
                          + num_type'(cp_ff[l][t][0]);
         end
      end
   end

   always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
         mag_in[l] = mag_type'(num_ff[l][NUM_BITS-1] ? -num_ff[l] : num_ff[l]);
         neg_in[l] = num_ff[l][NUM_BITS-1] ^ det_ff[7][DIFF_BITS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         prod_ff <= prod_in;
         pu_ff[0] <= pu_c;
         pv_ff[0] <= pv_c;
      end
      for (int s = 1; s < 5; s++) begin
         if (load[s]) begin
            pu_ff[s] <= pu_ff[s-1];
            pv_ff[s] <= pv_ff[s-1];
         end
      end
      if (load[1]) begin
         dot_ff <= dot_in;
      end
      if (load[2]) begin
         part_ff <= part_in;
      end
      if (load[3]) begin
         form_ff <= form_in;
      end
      if (load[4]) begin
         diff_ff <= diff_in;
      end
      if (load[5]) begin
         cp_ff <= cp_in;
         det_ff[5] <= diff_ff[0];
      end
      if (load[6]) begin
         term_ff <= term_in;
         det_ff[6] <= det_ff[5];
      end
      if (load[7]) begin
         for (int l = 0; l < NUM_LANES; l++) begin
            num_ff[l] <= term_ff[l][0] + term_ff[l][1];
         end
         det_ff[7] <= det_ff[6];
      end
      if (load[8]) begin
         mag_ff <= mag_in;
         dmag_ff <= dmag_type'(det_ff[7][DIFF_BITS-1] ? -det_ff[7] : det_ff[7]);
         neg_ff[8] <= neg_in;
         degen_ff[8] <= det_ff[7] == '0;
      end
      for (int s = 9; s <= STAGES - 2; s++) begin
         if (load[s]) begin
            neg_ff[s] <= neg_ff[s-1];
            degen_ff[s] <= degen_ff[s-1];
         end
      end
      if (load[STAGES-1]) begin
         du_ff <= du_in;
         dv_ff <= dv_in;
         degen_out_ff <= degen_ff[STAGES-2];
         sat_ff <= sat_in;
      end
   end

   wnd_divider u_divider (
      .clock    (clock),
      .load     (load[DIV_BASE +: QUO_BITS + 1]),
      .num_mag  (mag_ff),
      .den_mag  (dmag_ff),
      .quotient (quo),
      .over     (over)
   );

   // rounding, clipping and packing
   always_comb begin
      logic [QUO_BITS:0] rnd, lim, mag, val;
      logic clip;
      du_in = '0;
      dv_in = '0;
      sat_in = 1'b0;
      for (int l = 0; l < NUM_LANES; l++) begin
         rnd = ({1'b0, quo[l]} + ONE_Q) >> 1;
         lim = neg_ff[STAGES-2][l] ? LIM_NEG : LIM_POS;
         clip = over[l] || (rnd > lim);
         mag = clip ? lim : rnd;
         val = neg_ff[STAGES-2][l] ? (~mag + ONE_Q) : mag;
         if (degen_ff[STAGES-2]) begin
            val = '0;
            clip = 1'b0;
         end
         sat_in = sat_in | clip;
         if (l < AXES) begin
            du_in[(l % AXES)*COMP_BITS +: COMP_BITS] = val[COMP_BITS-1:0];
         end else begin
            dv_in[(l % AXES)*COMP_BITS +: COMP_BITS] = val[COMP_BITS-1:0];
         end
      end
   end

   assign rsp.normal_du = du_ff;
   assign rsp.normal_dv = dv_ff;
   assign rsp.degenerate = degen_out_ff;
   assign rsp.saturated = sat_ff;

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.degenerate |->
         rsp.normal_du == '0 && rsp.normal_dv == '0 && !rsp.saturated)
      else $error("degenerate response with nonzero payload");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (&v_ff) && !rsp.ready |-> !req.ready)
      else $error("request taken into a full stalled pipe");

   a_bubble_take: assert property (@(posedge clock) disable iff (reset)
      !(&v_ff) |-> req.ready)
      else $error("request refused while a stage is empty");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> v_ff == '0)
      else $error("valid bits survive reset");

endmodule

>>> bench/weingarten_normal_derivatives_unit_test.sv
// self-checking testbench for the weingarten normal derivatives unit
`timescale 1ns / 1ps

module weingarten_normal_derivatives_unit_test;
   import wnd_pkg::*;

   typedef logic [FIELD_BITS-1:0] field_type;
   typedef logic signed [127:0] wide_type;

   typedef struct {
      field_type unit_normal, deriv_u, deriv_v, deriv_uu, deriv_uv, deriv_vv;
   } surface_request_type;

   typedef struct {
      field_type normal_du, normal_dv;
      logic degenerate, saturated;
   } normal_slope_type;

   localparam int STALL_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 64;

   logic clock = 0;
   logic reset = 1;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int quiet_cycles = 0;

   wnd_req_if req_ch ();
   wnd_rsp_if rsp_ch ();

   weingarten_normal_derivatives_unit DUT (
      .clock(clock),
      .reset(reset),
      .req(req_ch),
      .rsp(rsp_ch)
   );

   always #5 clock = ~clock;

   function automatic wide_type lane(field_type w, int k);
      comp_type c;
      wide_type r;
      c = w[k*COMP_BITS +: COMP_BITS];
      r = wide_type'(c);
      return r;
   endfunction

   function automatic wide_type dot(field_type a, field_type b);
      wide_type s;
      s = 0;
      for (int k = 0; k < AXES; k++) s += lane(a, k) * lane(b, k);
      return s;
   endfunction

   function automatic comp_type rounded_quotient(wide_type num, wide_type den, inout logic sat);
      logic neg;
      logic [127:0] n, d, q, r, lim;
      neg = num[127] ^ den[127];
      n = num[127] ? -num : num;
      d = den[127] ? -den : den;
      q = n / d;
      r = n % d;
      if ((r << 1) >= d) q = q + 128'd1;
      lim = neg ? (128'd1 << (COMP_BITS-1)) : ((128'd1 << (COMP_BITS-1)) - 128'd1);
      if (q > lim) begin
         q = lim;
         sat = 1;
      end
      q = neg ? -q : q;
      return q[COMP_BITS-1:0];
   endfunction

   function automatic normal_slope_type weingarten_slopes(surface_request_type s);
      normal_slope_type o;
      wide_type e1, f1, g1, e2, f2, g2, det, a1, b1, a2, b2;
      logic sat;
      e1 = dot(s.deriv_u, s.deriv_u);
      f1 = dot(s.deriv_u, s.deriv_v);
      g1 = dot(s.deriv_v, s.deriv_v);
      e2 = dot(s.unit_normal, s.deriv_uu);
      f2 = dot(s.unit_normal, s.deriv_uv);
      g2 = dot(s.unit_normal, s.deriv_vv);
      det = e1 * g1 - f1 * f1;
      o.normal_du = '0;
      o.normal_dv = '0;
      o.saturated = 0;
      o.degenerate = (det == 0);
      if (o.degenerate) return o;
      a1 = f2 * f1 - e2 * g1;
      b1 = e2 * f1 - f2 * e1;
      a2 = g2 * f1 - f2 * g1;
      b2 = f2 * f1 - g2 * e1;
      sat = 0;
      for (int k = 0; k < AXES; k++) begin
         o.normal_du[k*COMP_BITS +: COMP_BITS] = rounded_quotient(
            a1 * lane(s.deriv_u, k) + b1 * lane(s.deriv_v, k), det, sat);
         o.normal_dv[k*COMP_BITS +: COMP_BITS] = rounded_quotient(
            a2 * lane(s.deriv_u, k) + b2 * lane(s.deriv_v, k), det, sat);
      end
      o.saturated = sat;
      return o;
   endfunction

   class slope_scoreboard;
      normal_slope_type pending[$];
      int errors = 0;

      task report(string what);
         $display("mismatch at %0t: %s", $realtime, what);
         errors++;
      endtask

      function void note_request(surface_request_type s);
         pending = {pending, weingarten_slopes(s)};
      endfunction

      task check_response(normal_slope_type got);
         normal_slope_type want;
         if (pending.size() == 0) begin
            report("response with no request outstanding");
            return;
         end
         want = pending.pop_front();
         if (got.normal_du !== want.normal_du)
            report($sformatf("normal_du got %h want %h", got.normal_du, want.normal_du));
         if (got.normal_dv !== want.normal_dv)
            report($sformatf("normal_dv got %h want %h", got.normal_dv, want.normal_dv));
         if (got.degenerate !== want.degenerate)
            report($sformatf("degenerate got %b want %b", got.degenerate, want.degenerate));
         if (got.saturated !== want.saturated)
            report($sformatf("saturated got %b want %b", got.saturated, want.saturated));
      endtask
   endclass

   slope_scoreboard board = new();

   initial begin
      req_ch.valid = 0;
      req_ch.unit_normal = '0;
      req_ch.deriv_u = '0;
      req_ch.deriv_v = '0;
      req_ch.deriv_uu = '0;
      req_ch.deriv_uv = '0;
      req_ch.deriv_vv = '0;
      rsp_ch.ready = 0;
   end

   always @(posedge clock) begin
      rsp_ch.ready <= !reset && ($urandom_range(99) >= receiver_stall_pct);
   end

   // request and response monitors
   always @(posedge clock) begin
      surface_request_type s;
      normal_slope_type r;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            s.unit_normal = req_ch.unit_normal;
            s.deriv_u = req_ch.deriv_u;
            s.deriv_v = req_ch.deriv_v;
            s.deriv_uu = req_ch.deriv_uu;
            s.deriv_uv = req_ch.deriv_uv;
            s.deriv_vv = req_ch.deriv_vv;
            board.note_request(s);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            r.normal_du = rsp_ch.normal_du;
            r.normal_dv = rsp_ch.normal_dv;
            r.degenerate = rsp_ch.degenerate;
            r.saturated = rsp_ch.saturated;
            board.check_response(r);
         end
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   task automatic send_request(surface_request_type s);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_ch.valid <= 0;
         @(posedge clock);
      end
      req_ch.valid <= 1;
      req_ch.unit_normal <= s.unit_normal;
      req_ch.deriv_u <= s.deriv_u;
      req_ch.deriv_v <= s.deriv_v;
      req_ch.deriv_uu <= s.deriv_uu;
      req_ch.deriv_uv <= s.deriv_uv;
      req_ch.deriv_vv <= s.deriv_vv;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   function automatic field_type pack3(int x, int y, int z);
      comp_type cx, cy, cz;
      cx = comp_type'(x);
      cy = comp_type'(y);
      cz = comp_type'(z);
      return {cz, cy, cx};
   endfunction

   function automatic field_type random_field(int span);
      if (span == 0) return field_type'({$urandom, $urandom});
      return pack3(int'($urandom_range(2*span)) - span, int'($urandom_range(2*span)) - span,
                   int'($urandom_range(2*span)) - span);
   endfunction

   function automatic surface_request_type random_request();
      surface_request_type s;
      int pick, span;
      pick = $urandom_range(99);
      span = (pick < 15) ? 0 : (pick < 30) ? 16 : (pick < 85) ? 2048 : 200000;
      s.unit_normal = random_field(span);
      s.deriv_u = random_field(span);
      s.deriv_v = random_field(span);
      s.deriv_uu = random_field(span);
      s.deriv_uv = random_field(span);
      s.deriv_vv = random_field(span);
      pick = $urandom_range(99);
      if (pick < 4) s.deriv_v = s.deriv_u;
      else if (pick < 7) s.deriv_u = '0;
      else if (pick < 10) s.deriv_v = pack3(int'(-lane(s.deriv_u, 0)),
                                            int'(-lane(s.deriv_u, 1)),
                                            int'(-lane(s.deriv_u, 2)));
      return s;
   endfunction

   function automatic surface_request_type make_request(field_type n, field_type u,
                                                        field_type v, field_type uu,
                                                        field_type uv, field_type vv);
      surface_request_type s;
      s.unit_normal = n;
      s.deriv_u = u;
      s.deriv_v = v;
      s.deriv_uu = uu;
      s.deriv_uv = uv;
      s.deriv_vv = vv;
      return s;
   endfunction

   initial begin
      surface_request_type plan[$];
      int lo, hi;
      lo = -(1 << (COMP_BITS-1));
      hi = (1 << (COMP_BITS-1)) - 1;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed corner requests
      plan = {plan, make_request('0, '0, '0, '0, '0, '0)};
      plan = {plan, make_request('1, '1, '1, '1, '1, '1)};
      plan = {plan, make_request(pack3(0, 0, 1024), pack3(1024, 0, 0), pack3(0, 1024, 0),
                                 pack3(0, 0, 512), pack3(0, 0, 0), pack3(0, 0, 512))};
      plan = {plan, make_request(pack3(0, 0, 1024), pack3(1024, 0, 0), pack3(0, 1024, 0),
                                 pack3(0, 0, -300), pack3(7, 3, 200), pack3(0, 0, 900))};
      plan = {plan, make_request(pack3(0, 0, 5000), pack3(1024, 0, 0), pack3(0, 1024, 0),
                                 pack3(0, 0, 800), pack3(0, 0, 100), pack3(0, 0, -800))};
      plan = {plan, make_request(pack3(hi, hi, hi), pack3(1, 0, 0), pack3(0, 1, 0),
                                 pack3(hi, hi, hi), pack3(hi, lo, hi), pack3(lo, lo, lo))};
      plan = {plan, make_request(pack3(lo, lo, lo), pack3(hi, hi, hi), pack3(lo, lo, lo),
                                 pack3(hi, lo, hi), pack3(lo, hi, lo), pack3(hi, hi, lo))};
      plan = {plan, make_request(pack3(lo, hi, lo), pack3(hi, 0, 0), pack3(0, lo, 0),
                                 pack3(lo, lo, lo), pack3(hi, hi, hi), pack3(lo, hi, lo))};
      plan = {plan, make_request(pack3(hi, 0, 0), pack3(lo, 0, 0), pack3(0, 0, hi),
                                 pack3(hi, 0, 0), pack3(lo, 0, 0), pack3(hi, 0, 0))};
      plan = {plan, make_request(pack3(1, 1, 1), pack3(3, 4, 0), pack3(6, 8, 0),
                                 pack3(1, 1, 1), pack3(1, 1, 1), pack3(1, 1, 1))};
      plan = {plan, make_request(pack3(1, 2, 3), pack3(1, 0, 0), pack3(1, 1, 0),
                                 pack3(1, 0, 0), pack3(0, 1, 0), pack3(0, 0, 1))};
      plan = {plan, make_request(pack3(0, 0, 1), pack3(2, 0, 0), pack3(0, 2, 0),
                                 pack3(0, 0, 1), pack3(0, 0, -1), pack3(0, 0, 3))};
      plan = {plan, make_request(pack3(0, 0, 1024), pack3(1024, 0, 0), pack3(0, 1024, 0),
                                 pack3(0, 0, 512), pack3(0, 0, 0), pack3(0, 0, 512))};
      plan = {plan, make_request({FIELD_BITS/2{2'b10}}, {FIELD_BITS/2{2'b01}},
                                 {FIELD_BITS/2{2'b10}}, {FIELD_BITS/2{2'b01}},
                                 {FIELD_BITS/2{2'b10}}, {FIELD_BITS/2{2'b01}})};
      foreach (plan[i]) send_request(plan[i]);

      for (int phase = 0; phase < 4; phase++) begin
         sender_idle_pct = (phase == 1) ? 88 : (phase == 3) ? 10 : 0;
         receiver_stall_pct = (phase == 2) ? 88 : (phase == 3) ? 10 : 0;
         repeat (310) send_request(random_request());
      end
      req_ch.valid <= 0;
      receiver_stall_pct = 0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
